// File: rtl/b64sd_pkg.sv
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, codes and the character lookup shared by the strict base64 decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

    // sextet lookup markers outside the six-bit range
    localparam logic [7:0] PAD_CODE = 8'd254;
    localparam logic [7:0] BAD_CODE = 8'd255;

    // ascii codes of the alphabet boundaries
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_SLASH   = 8'h2F;
    localparam logic [7:0] CHR_EQUALS  = 8'h3D;

    // group position of the fourth character
    localparam logic [1:0] POS_LAST = 2'd3;

    // error codes carried on results
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_BAD_CHAR    = 3'd1,
        ERR_BAD_PADDING = 3'd2,
        ERR_LENGTH      = 3'd3,
        ERR_UNUSED_BITS = 3'd4
    } t_err_code;

    // one input transfer
    typedef struct packed {
        logic [7:0] in_char;
        logic       frame_last;
    } t_b64_in;

    // one result transfer
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        t_err_code  error_code;
    } t_b64_out;

    // character to sextet, or one of the pad and bad markers
    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
            v = c - CHR_UPPER_A;
        end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
            v = c - CHR_LOWER_A + 8'd26;
        end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
            v = c - CHR_DIGIT_0 + 8'd52;
        end else if (c == CHR_PLUS) begin
            v = 8'd62;
        end else if (c == CHR_SLASH) begin
            v = 8'd63;
        end else if (c == CHR_EQUALS) begin
            v = PAD_CODE;
        end else begin
            v = BAD_CODE;
        end
        return v;
    endfunction

endpackage

// File: rtl/base64_strict_decoder.sv
// ----------------------------------------------------------------------------
// base64_strict_decoder
// Strict standard-alphabet base64 decoder, one character per transfer.
//
//   channel  direction  handshake                   payload
//   input    in         i_in_valid / o_in_ready     i_in_data  (t_b64_in)
//   output   out        o_out_valid / i_out_ready   o_out_data (t_b64_out)
//
// A character is registered on entry and decoded from that register into
// a three-slot result register once that register can take its results;
// it then presents one result per cycle while the output is ready. A
// character that gives no result moves on every cycle; one that gives
// results waits only until the previous results have drained.
// Synchronous active-low reset clears the group state and empties both
// registers. A stalled output holds its result and back-pressures the input.
// ----------------------------------------------------------------------------
module base64_strict_decoder
    import b64sd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_b64_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_b64_out o_out_data
);

    // input register
    logic       r_in_valid;
    t_b64_in    r_in;

    // decoder state
    logic [1:0]  r_pos,  n_pos;
    logic [17:0] r_acc,  n_acc;
    logic [1:0]  r_pcnt, n_pcnt;
    logic        r_skip, n_skip;

    // result register, slot 0 is presented
    t_b64_out   r_slot [3];
    logic [1:0] r_cnt;

    // decode outputs
    t_b64_out   res [3];
    logic [1:0] res_n;

    logic [7:0] v;
    logic       pad;
    logic [5:0] s0, s1, s2;
    logic       fail;
    t_err_code  fail_code;
    logic       can_take;
    logic       dec_fire;
    logic       out_pop;

    // character classification and stored sextets
    always_comb begin
        v   = sextet_of(r_in.in_char);
        pad = (v == PAD_CODE);
        s0  = r_acc[17:12];
        s1  = r_acc[11:6];
        s2  = r_acc[5:0];
    end

    // checks in priority order
    always_comb begin
        fail      = 1'b1;
        fail_code = ERR_NONE;
        priority if (v == BAD_CODE) begin
            fail_code = ERR_BAD_CHAR;
        end else if (r_pcnt != 2'd0 && !pad) begin
            fail_code = ERR_BAD_PADDING;
        end else if (pad && r_pos < 2'd2) begin
            fail_code = ERR_BAD_PADDING;
        end else if (pad && r_pos == POS_LAST && !r_in.frame_last) begin
            fail_code = ERR_BAD_PADDING;
        end else if (r_in.frame_last && r_pos != POS_LAST) begin
            fail_code = ERR_LENGTH;
        end else if (r_pos == POS_LAST && pad && r_pcnt != 2'd0 && s1[3:0] != 4'd0) begin
            fail_code = ERR_UNUSED_BITS;
        end else if (r_pos == POS_LAST && pad && r_pcnt == 2'd0 && s2[1:0] != 2'd0) begin
            fail_code = ERR_UNUSED_BITS;
        end else begin
            fail = 1'b0;
        end
    end

    // next state and results for the registered character
    always_comb begin
        n_pos  = r_pos;
        n_acc  = r_acc;
        n_pcnt = r_pcnt;
        n_skip = r_skip;
        res_n  = 2'd0;
        for (int k = 0; k < 3; k++) begin
            res[k] = '{out_byte: 8'd0, byte_valid: 1'b0, frame_end: 1'b0,
                       error_code: ERR_NONE};
        end

        if (r_skip) begin
            // dropping to the end of a failed frame
            if (r_in.frame_last) begin
                n_skip = 1'b0;
            end
        end else if (fail) begin
            // single error result, group cleared
            res_n            = 2'd1;
            res[0].frame_end  = 1'b1;
            res[0].error_code = fail_code;
            n_pos  = 2'd0;
            n_acc  = '0;
            n_pcnt = 2'd0;
            n_skip = !r_in.frame_last;
        end else if (r_pos != POS_LAST) begin
            // collect one sextet, a pad stored as zero
            n_acc = {r_acc[11:0], pad ? 6'd0 : v[5:0]};
            n_pos = r_pos + 2'd1;
            if (pad) begin
                n_pcnt = r_pcnt + 2'd1;
            end
        end else begin
            // group complete
            n_pos  = 2'd0;
            n_acc  = '0;
            n_pcnt = 2'd0;
            res[0].out_byte   = {s0, s1[5:4]};
            res[0].byte_valid = 1'b1;
            res[1].out_byte   = {s1[3:0], s2[5:2]};
            res[1].byte_valid = 1'b1;
            res[2].out_byte   = {s2[1:0], v[5:0]};
            res[2].byte_valid = 1'b1;
            if (!pad) begin
                res_n            = 2'd3;
                res[2].frame_end = r_in.frame_last;
            end else if (r_pcnt != 2'd0) begin
                res_n            = 2'd1;
                res[0].frame_end = 1'b1;
            end else begin
                res_n            = 2'd2;
                res[1].frame_end = 1'b1;
            end
        end
    end

    // handshake between the stages
    always_comb begin
        out_pop    = o_out_valid && i_out_ready;
        can_take   = (res_n == 2'd0) || (r_cnt == 2'd0) ||
                     (r_cnt == 2'd1 && i_out_ready);
        dec_fire   = r_in_valid && can_take;
        o_in_ready = !r_in_valid || can_take;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 2'd0;
            r_acc  <= '0;
            r_pcnt <= 2'd0;
            r_skip <= 1'b0;
        end else if (dec_fire) begin
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_pcnt <= n_pcnt;
            r_skip <= n_skip;
        end
    end

    // result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (dec_fire && res_n != 2'd0) begin
            r_cnt <= res_n;
        end else if (out_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // result slots, load a new set or shift towards slot 0
    always_ff @(posedge i_clk) begin
        if (dec_fire && res_n != 2'd0) begin
            r_slot[0] <= res[0];
            r_slot[1] <= res[1];
            r_slot[2] <= res[2];
        end else if (out_pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_slot[0];

    // results are never loaded over ones still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dec_fire && res_n != 2'd0 |-> r_cnt == 2'd0 || (r_cnt == 2'd1 && i_out_ready))
        else $error("result register overwritten");

    // an error result closes the frame and carries no byte
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_code != ERR_NONE |->
            o_out_data.frame_end && !o_out_data.byte_valid)
        else $error("malformed error result");

    // skipping only ever follows a cleared group
    a_skip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> r_pos == 2'd0 && r_pcnt == 2'd0)
        else $error("group state left while skipping");

    // padding is only held ahead of the fourth character
    a_pad_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt != 2'd0 |-> r_pos == POS_LAST)
        else $error("padding held at wrong position");

endmodule

// File: dv/base64_strict_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_strict_decoder_test
// Self-checking bench for the strict base64 decoder. Characters are queued
// up front, sent by a clocked driver with random gaps, and decoded again by
// a bench-side decoder as each transfer is accepted. A monitor checks every
// result transfer against the oldest decoded expectation, with random and
// long stalls on the output side.
// ----------------------------------------------------------------------------
module base64_strict_decoder_test
    import b64sd_pkg::*;
();

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_b64_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_b64_out o_out_data;

    // characters waiting to be sent, decoded results still owed
    t_b64_in  char_queue[$];
    t_b64_out decoded_queue[$];

    // bench-side decoder state
    logic [1:0]  grp_pos   = '0;
    logic [17:0] sext_acc  = '0;
    logic [1:0]  pad_seen  = '0;
    logic        skipping  = 1'b0;
    logic [7:0]  sextet_lut [256];

    int fail_count     = 0;
    int accepted_count = 0;
    int total_items    = 0;
    int tx_gap         = 0;
    int tx_quiet       = 0;
    int rx_gap         = 0;
    int rx_quiet       = 0;
    logic rx_hold      = 1'b0;

    base64_strict_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // alphabet character for a sextet
    function automatic logic [7:0] b64_char(input logic [5:0] s);
        if (s < 6'd26) return CHR_UPPER_A + 8'(s);
        if (s < 6'd52) return CHR_LOWER_A + 8'(s - 6'd26);
        if (s < 6'd62) return CHR_DIGIT_0 + 8'(s - 6'd52);
        if (s == 6'd62) return CHR_PLUS;
        return CHR_SLASH;
    endfunction

    // idle length: mostly none, some short, a few long, with quiet runs
    function automatic int draw_gap(inout int quiet_run);
        int r;
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            quiet_run = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 40) $display("%0t ns: %s", $time, msg);
    endtask

    task automatic owe_result(input logic [7:0] b, input logic valid, input logic fin,
                              input t_err_code err);
        t_b64_out r;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.frame_end  = fin;
        r.error_code = err;
        decoded_queue.insert(decoded_queue.size(), r);
    endtask

    task automatic clear_group();
        grp_pos  = '0;
        sext_acc = '0;
        pad_seen = '0;
    endtask

    // decode one accepted character into the results it owes
    task automatic decode_char(input t_b64_in it);
        logic [7:0] v;
        logic       pad;
        logic       last;
        logic [5:0] s0, s1, s2;
        t_err_code  err;
        last = it.frame_last;
        if (skipping) begin
            if (last) begin
                clear_group();
                skipping = 1'b0;
            end
            return;
        end
        v   = sextet_lut[it.in_char];
        pad = (v == PAD_CODE);
        s0  = sext_acc[17:12];
        s1  = sext_acc[11:6];
        s2  = sext_acc[5:0];
        err = ERR_NONE;
        // checks in priority order
        if (v == BAD_CODE) err = ERR_BAD_CHAR;
        else if (pad_seen != 2'd0 && !pad) err = ERR_BAD_PADDING;
        else if (pad && grp_pos < 2'd2) err = ERR_BAD_PADDING;
        else if (pad && grp_pos == POS_LAST && !last) err = ERR_BAD_PADDING;
        else if (last && grp_pos != POS_LAST) err = ERR_LENGTH;
        else if (pad && grp_pos == POS_LAST) begin
            if (pad_seen != 2'd0 && s1[3:0] != 4'd0) err = ERR_UNUSED_BITS;
            else if (pad_seen == 2'd0 && s2[1:0] != 2'd0) err = ERR_UNUSED_BITS;
        end
        if (err != ERR_NONE) begin
            owe_result(8'd0, 1'b0, 1'b1, err);
            clear_group();
            skipping = !last;
            return;
        end
        // still filling the group
        if (grp_pos != POS_LAST) begin
            sext_acc = {sext_acc[11:0], pad ? 6'd0 : v[5:0]};
            grp_pos  = grp_pos + 2'd1;
            if (pad) pad_seen = pad_seen + 2'd1;
            return;
        end
        // group complete
        if (!pad) begin
            owe_result({s0, s1[5:4]}, 1'b1, 1'b0, ERR_NONE);
            owe_result({s1[3:0], s2[5:2]}, 1'b1, 1'b0, ERR_NONE);
            owe_result({s2[1:0], v[5:0]}, 1'b1, last, ERR_NONE);
        end else if (pad_seen != 2'd0) begin
            owe_result({s0, s1[5:4]}, 1'b1, 1'b1, ERR_NONE);
        end else begin
            owe_result({s0, s1[5:4]}, 1'b1, 1'b0, ERR_NONE);
            owe_result({s1[3:0], s2[5:2]}, 1'b1, 1'b1, ERR_NONE);
        end
        clear_group();
    endtask

    task automatic queue_char(input logic [7:0] c, input logic last);
        t_b64_in it;
        it.in_char    = c;
        it.frame_last = last;
        char_queue.insert(char_queue.size(), it);
    endtask

    task automatic queue_text(input string txt, input logic ends_frame);
        for (int i = 0; i < txt.len(); i++)
            queue_char(txt[i], ends_frame && (i == txt.len() - 1));
    endtask

    // one random frame: mostly well formed, some corrupted or pure noise
    task automatic queue_random_frame();
        logic [5:0] sx[$];
        logic [7:0] chars[$];
        int groups, pads, n, kind, pos;
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
        pads   = $urandom_range(0, 2);
        n      = groups * 4;
        for (int i = 0; i < n; i++) sx.insert(sx.size(), 6'($urandom_range(0, 63)));
        // keep the unused bits clean most of the time
        if ($urandom_range(0, 99) < 85) begin
            if (pads == 1) sx[n-2] = sx[n-2] & 6'h3C;
            if (pads == 2) sx[n-3] = sx[n-3] & 6'h30;
        end
        for (int i = 0; i < n; i++)
            chars.insert(chars.size(), (i >= n - pads) ? CHR_EQUALS : b64_char(sx[i]));
        kind = $urandom_range(0, 99);
        pos  = $urandom_range(0, chars.size() - 1);
        if (kind < 75) begin
            // well formed
        end else if (kind < 82) begin
            chars[pos] = 8'($urandom_range(0, 255));
        end else if (kind < 88) begin
            chars.insert(pos, CHR_EQUALS);
        end else if (kind < 94) begin
            chars.delete(pos);
            if (chars.size() == 0)
                chars.insert(chars.size(), b64_char(6'($urandom_range(0, 63))));
        end else begin
            chars.delete();
            repeat ($urandom_range(1, 8))
                chars.insert(chars.size(), 8'($urandom_range(0, 255)));
        end
        foreach (chars[i]) queue_char(chars[i], i == chars.size() - 1);
    endtask

    // stimulus, reset and end of run
    initial begin
        for (int i = 0; i < 256; i++) sextet_lut[i] = BAD_CODE;
        for (int s = 0; s < 64; s++) sextet_lut[b64_char(6'(s))] = 8'(s);
        sextet_lut[CHR_EQUALS] = PAD_CODE;

        // directed frames
        queue_text("+/9zAg==", 1'b1);   // full group then two pads
        queue_text("Zm9=", 1'b1);       // stray bits before single pad
        queue_char(8'hFF, 1'b0);        // high code is a bad character
        queue_char(8'h00, 1'b1);        // skipped up to frame end
        queue_text("AB=C", 1'b1);       // data after pad
        queue_text("=", 1'b1);          // pad in first position, on final char
        queue_text("AB=", 1'b1);        // short frame ending in pad
        queue_text("ABC=", 1'b0);       // fourth-position pad not at frame end
        queue_text("D", 1'b1);

        // random frames
        while (char_queue.size() < 315) queue_random_frame();
        total_items = char_queue.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count != total_items) @(negedge i_clk);
        while (decoded_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("base64_strict_decoder_test passed");
        end else begin
            $display("base64_strict_decoder_test failed");
        end
        $finish;
    end

    // long output stall while characters keep coming
    initial begin
        while (accepted_count < 120) @(negedge i_clk);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("base64_strict_decoder_test failed");
        $finish;
    end

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (char_queue.size() != 0) begin
                i_in_data  <= char_queue.pop_front();
                i_in_valid <= 1'b1;
                tx_gap = draw_gap(tx_quiet);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) rx_gap = draw_gap(rx_quiet);
            else if (rx_gap > 0) rx_gap--;
            i_out_ready <= (rx_gap == 0) && !rx_hold;
        end
    end

    // monitor: decode accepted characters, check result transfers
    always @(posedge i_clk) begin : monitor
        t_b64_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                decode_char(i_in_data);
                accepted_count++;
            end
            if (o_out_valid && i_out_ready) begin
                if (decoded_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_out_data));
                end else begin
                    want = decoded_queue.pop_front();
                    if (o_out_data.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                        o_out_data.out_byte, want.out_byte));
                    if (o_out_data.byte_valid !== want.byte_valid)
                        report_mismatch($sformatf("byte_valid got %b want %b",
                                        o_out_data.byte_valid, want.byte_valid));
                    if (o_out_data.frame_end !== want.frame_end)
                        report_mismatch($sformatf("frame_end got %b want %b",
                                        o_out_data.frame_end, want.frame_end));
                    if (o_out_data.error_code !== want.error_code)
                        report_mismatch($sformatf("error_code got %0d want %0d",
                                        o_out_data.error_code, want.error_code));
                end
            end
        end
    end

endmodule
